// File: sv/scms_pkg.sv
// ----------------------------------------------------------------------------
// scms_pkg
// Shared types, codes and helpers of the sorted counted multiset.
// ----------------------------------------------------------------------------
package scms_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned OccW   = 16;
  localparam int unsigned DistW  = 7;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } entry_t;

  // saturating unsigned add
  function automatic logic [CountW-1:0] sat_add(logic [CountW-1:0] a, logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? {CountW{1'b1}} : s[CountW-1:0];
  endfunction

endpackage

// File: sv/scms_in_if.sv
// ----------------------------------------------------------------------------
// scms_in_if
// Request channel: action, key and occurrence count with valid/ready.
// ----------------------------------------------------------------------------
interface scms_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] key;
  logic [15:0]        occurrences;

  modport source (output valid, output action, output key, output occurrences, input ready);
  modport sink   (input valid, input action, input key, input occurrences, output ready);
endinterface

// File: sv/scms_out_if.sv
// ----------------------------------------------------------------------------
// scms_out_if
// Result channel: membership, status and summary of the set with valid/ready.
// ----------------------------------------------------------------------------
interface scms_out_if;
  logic               valid;
  logic               ready;
  logic               present;
  logic [1:0]         status;
  logic [31:0]        total_count;
  logic [6:0]         distinct_count;
  logic signed [31:0] smallest_key;
  logic               is_empty;

  modport source (output valid, output present, output status, output total_count,
                  output distinct_count, output smallest_key, output is_empty,
                  input ready);
  modport sink   (input valid, input present, input status, input total_count,
                  input distinct_count, input smallest_key, input is_empty,
                  output ready);
endinterface

// File: sv/sorted_counted_multiset.sv
// Operation: each transaction searches the table linearly from entry zero over the N
// distinct keys held; an insert or drop that shifts entries then moves them as well.
// Concurrency: one transaction at a time; a new request is taken only back in idle, after
// the linear search and the entry shift through the single-port-read table memory are done.
// Reset: empty set, zero total; table memory contents are not initialized or cleared.
// ----------------------------------------------------------------------------
// sorted_counted_multiset
// Ascending table of distinct signed keys with counts, held in one synchronous
// memory; searched and shifted one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
module sorted_counted_multiset #(
  parameter int unsigned DEPTH = scms_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scms_in_if.sink     in_i,
  scms_out_if.source  out_o
);
  import scms_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // table memory
  entry_t store_q [DEPTH];
  entry_t rd_q;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  logic [2:0]        state_q, state_d;
  logic [1:0]        act_q, act_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [AW-1:0]     rc_q, rc_d;
  logic              more_q, more_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pa_q, pa_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CountW-1:0] total_q, total_d;
  logic [KeyW-1:0]   head_q, head_d;
  logic              hit_q, hit_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [1:0]        status_q, status_d;

  logic              out_valid_q, out_valid_d;
  logic              out_present_q, out_present_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [CountW-1:0] out_total_q, out_total_d;
  logic [DistW-1:0]  out_dist_q, out_dist_d;
  logic [KeyW-1:0]   out_small_q, out_small_d;
  logic              out_empty_q, out_empty_d;

  logic              ge, eq, found, f_hit;
  logic [CW-1:0]     f_pos;
  logic [AW-1:0]     used_m1;
  logic [CountW-1:0] occ_ext;

  assign ge      = $signed(rd_q.key) >= $signed(key_q);
  assign eq      = (rd_q.key == key_q);
  assign found   = pend_q && ge;
  assign f_hit   = found && eq;
  assign f_pos   = found ? {1'b0, pa_q} : used_q;
  assign used_m1 = AW'(used_q - CW'(1));
  assign occ_ext = CountW'(occ_q);

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    key_d    = key_q;
    occ_d    = occ_q;
    rc_d     = rc_q;
    more_d   = more_q;
    pend_d   = 1'b0;
    pa_d     = pa_q;
    used_d   = used_q;
    total_d  = total_q;
    hit_d    = hit_q;
    pos_d    = pos_q;
    status_d = status_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;

    out_valid_d   = out_valid_q && !out_o.ready;
    out_present_d = out_present_q;
    out_status_d  = out_status_q;
    out_total_d   = out_total_q;
    out_dist_d    = out_dist_q;
    out_small_d   = out_small_q;
    out_empty_d   = out_empty_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          key_d   = in_i.key;
          occ_d   = in_i.occurrences;
          rc_d    = '0;
          more_d  = (used_q != '0);
          state_d = S_SRCH;
        end
      end

      S_SRCH: begin
        if (more_q && !found) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pa_d   = rc_q;
          if (rc_q == used_m1) begin
            more_d = 1'b0;
          end else begin
            rc_d = rc_q + AW'(1);
          end
        end
        // stop at the first key not below the search key, or past the last entry
        if (found || !more_q) begin
          hit_d    = f_hit;
          pos_d    = f_pos;
          status_d = STATUS_OK;
          state_d  = S_DONE;
          case (act_q)
            ACT_INSERT: begin
              if (occ_q != '0) begin
                if (f_hit) begin
                  mem_we  = 1'b1;
                  mem_wa  = pa_q;
                  mem_wd  = '{key: key_q, count: sat_add(rd_q.count, occ_ext)};
                  total_d = sat_add(total_q, occ_ext);
                end else if (used_q == CW'(DEPTH)) begin
                  status_d = STATUS_FULL;
                end else if (f_pos == used_q) begin
                  mem_we  = 1'b1;
                  mem_wa  = used_q[AW-1:0];
                  mem_wd  = '{key: key_q, count: occ_ext};
                  used_d  = used_q + CW'(1);
                  total_d = sat_add(total_q, occ_ext);
                end else begin
                  rc_d    = used_m1;
                  more_d  = 1'b1;
                  state_d = S_SHUP;
                end
              end
            end
            ACT_REMOVE: begin
              if (!f_hit) begin
                status_d = STATUS_NOTFOUND;
              end else begin
                if (total_q != '0) begin
                  total_d = total_q - CountW'(1);
                end
                if (rd_q.count > CountW'(1)) begin
                  mem_we = 1'b1;
                  mem_wa = pa_q;
                  mem_wd = '{key: rd_q.key, count: rd_q.count - CountW'(1)};
                end else if (pa_q == used_m1) begin
                  used_d = used_q - CW'(1);
                end else begin
                  rc_d    = pa_q + AW'(1);
                  more_d  = 1'b1;
                  state_d = S_SHDN;
                end
              end
            end
            ACT_QUERY: begin
            end
            ACT_CLEAR: begin
              used_d  = '0;
              total_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // move entries pos..used-1 up by one, top first, then drop the new key in
      S_SHUP: begin
        if (more_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pa_d   = rc_q;
          if (rc_q == pos_q[AW-1:0]) begin
            more_d = 1'b0;
          end else begin
            rc_d = rc_q - AW'(1);
          end
        end
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pa_q + AW'(1);
          mem_wd = rd_q;
        end
        if (!more_q && !pend_q) begin
          mem_we  = 1'b1;
          mem_wa  = pos_q[AW-1:0];
          mem_wd  = '{key: key_q, count: occ_ext};
          used_d  = used_q + CW'(1);
          total_d = sat_add(total_q, occ_ext);
          state_d = S_DONE;
        end
      end

      // move entries pos+1..used-1 down by one over the dropped entry
      S_SHDN: begin
        if (more_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pa_d   = rc_q;
          if (rc_q == used_m1) begin
            more_d = 1'b0;
          end else begin
            rc_d = rc_q + AW'(1);
          end
        end
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pa_q - AW'(1);
          mem_wd = rd_q;
        end
        if (!more_q && !pend_q) begin
          used_d  = used_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_present_d = hit_q;
          out_status_d  = status_q;
          out_total_d   = total_q;
          out_dist_d    = DistW'(used_q);
          out_small_d   = (used_q != '0) ? head_q : '0;
          out_empty_d   = (used_q == '0);
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // shadow of the key in entry zero
  assign head_d = (mem_we && (mem_wa == '0)) ? mem_wd.key : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= store_q[rc_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      used_q      <= used_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    key_q         <= key_d;
    occ_q         <= occ_d;
    rc_q          <= rc_d;
    pa_q          <= pa_d;
    head_q        <= head_d;
    hit_q         <= hit_d;
    pos_q         <= pos_d;
    status_q      <= status_d;
    out_present_q <= out_present_d;
    out_status_q  <= out_status_d;
    out_total_q   <= out_total_d;
    out_dist_q    <= out_dist_d;
    out_small_q   <= out_small_d;
    out_empty_q   <= out_empty_d;
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.present        = out_present_q;
  assign out_o.status         = out_status_q;
  assign out_o.total_count    = out_total_q;
  assign out_o.distinct_count = out_dist_q;
  assign out_o.smallest_key   = out_small_q;
  assign out_o.is_empty       = out_empty_q;

endmodule

// File: tb/sorted_counted_multiset_tb.sv
// ----------------------------------------------------------------------------
// sorted_counted_multiset_tb
// Drives insert, remove, query and clear transactions into the multiset and
// checks every result against a behavioral copy of the sorted count table.
// A directed opening covers empty-set removes, zero-count inserts, merges,
// signed key ordering and clear. Randomized phases follow: fill runs that
// reach a full table, drain runs that remove held keys, and mixed traffic.
// Both sides idle in random bursts. The last stretch of the run has none.
// ----------------------------------------------------------------------------
module sorted_counted_multiset_tb;
  import scms_pkg::*;

  localparam int unsigned DEPTH       = DefaultDepth;
  localparam int unsigned RandomItems = 1650;
  localparam int unsigned CalmFrom    = 1480;
  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned TailCycles  = 2 * DEPTH + 20;

  typedef struct packed {
    logic [1:0]         act;
    logic signed [31:0] key;
    logic [15:0]        occ;
    bit                 drain;
    bit                 calm;
  } op_item_t;

  typedef struct packed {
    logic               present;
    logic [1:0]         status;
    logic [31:0]        total;
    logic [6:0]         distinct;
    logic signed [31:0] least;
    logic               vacant;
  } summary_t;

  logic clk_i;
  logic rst_n;

  scms_in_if  req_if ();
  scms_out_if rsp_if ();

  sorted_counted_multiset #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // behavioral copy of the table
  logic signed [31:0] tbl_key [DEPTH];
  logic [31:0]        tbl_cnt [DEPTH];
  int unsigned        held = 0;
  logic [31:0]        grand_total = '0;

  op_item_t    pending_ops [$];
  summary_t    due_summaries [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_odds = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        in_fire = 1'b0;
  bit          tail_calm = 1'b0;
  bit          calm_mode = 1'b0;

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // apply one transaction to the copy and return the summary it yields
  function automatic summary_t multiset_apply(logic [1:0] act, logic signed [31:0] k,
                                              logic [15:0] occ);
    summary_t    res;
    int unsigned pos;
    bit          found;
    bit          hit;
    pos   = held;
    found = 1'b0;
    hit   = 1'b0;
    res   = '0;
    for (int unsigned i = 0; i < held; i++) begin
      if (!found && tbl_key[i] >= k) begin
        found = 1'b1;
        pos   = i;
        hit   = (tbl_key[i] == k);
      end
    end
    res.status = STATUS_OK;
    case (act)
      ACT_INSERT: begin
        if (occ != 0) begin
          if (hit) begin
            tbl_cnt[pos] = add_clamped(tbl_cnt[pos], {16'd0, occ});
            grand_total  = add_clamped(grand_total, {16'd0, occ});
          end else if (held >= DEPTH) begin
            res.status = STATUS_FULL;
          end else begin
            for (int unsigned j = held; j > pos; j--) begin
              tbl_key[j] = tbl_key[j-1];
              tbl_cnt[j] = tbl_cnt[j-1];
            end
            tbl_key[pos] = k;
            tbl_cnt[pos] = {16'd0, occ};
            held++;
            grand_total = add_clamped(grand_total, {16'd0, occ});
          end
        end
      end
      ACT_REMOVE: begin
        if (!hit) begin
          res.status = STATUS_NOTFOUND;
        end else begin
          if (grand_total != 0) grand_total--;
          if (tbl_cnt[pos] > 1) begin
            tbl_cnt[pos]--;
          end else begin
            for (int unsigned j = pos; j + 1 < held; j++) begin
              tbl_key[j] = tbl_key[j+1];
              tbl_cnt[j] = tbl_cnt[j+1];
            end
            held--;
          end
        end
      end
      ACT_CLEAR: begin
        held        = 0;
        grand_total = '0;
      end
      default: ;
    endcase
    res.present  = hit;
    res.total    = grand_total;
    res.distinct = held[6:0];
    res.least    = (held != 0) ? tbl_key[0] : '0;
    res.vacant   = (held == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void queue_op(logic [1:0] act, logic signed [31:0] k, logic [15:0] occ,
                                   bit drain);
    op_item_t it;
    it.act   = act;
    it.key   = k;
    it.occ   = occ;
    it.drain = drain;
    it.calm  = calm_mode;
    pending_ops.push_back(it);
  endfunction

  function automatic logic signed [31:0] rand_key();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic [15:0] rand_occ();
    case ($urandom_range(0, 19))
      0:             return 16'd0;
      1:             return 16'hFFFF;
      2, 3, 4:       return 16'($urandom);
      default:       return 16'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // reset, stimulus and end of run
  initial begin : stimulus
    logic signed [31:0] pool [$];
    int unsigned        made;
    int unsigned        mode;
    int unsigned        len;
    int unsigned        r;
    logic [1:0]         act;
    logic signed [31:0] k;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_QUERY;
    req_if.key         = '0;
    req_if.occurrences = '0;
    rsp_if.ready       = 1'b0;

    // directed opening
    queue_op(ACT_REMOVE, 32'sd5, 16'd1, 1'b0);
    queue_op(ACT_QUERY, 32'sd0, 16'd0, 1'b0);
    queue_op(ACT_CLEAR, -32'sd1, 16'hFFFF, 1'b0);
    queue_op(ACT_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
    queue_op(ACT_INSERT, 32'sh8000_0000, 16'd1, 1'b0);
    queue_op(ACT_INSERT, 32'sd0, 16'd0, 1'b0);
    queue_op(ACT_INSERT, -32'sd1, 16'h8000, 1'b0);
    queue_op(ACT_INSERT, 32'sh7FFF_FFFF, 16'd1, 1'b0);
    queue_op(ACT_QUERY, -32'sd1, 16'd7, 1'b0);
    queue_op(ACT_QUERY, 32'sd12345, 16'd0, 1'b0);
    queue_op(ACT_REMOVE, 32'sh8000_0000, 16'd0, 1'b0);
    queue_op(ACT_REMOVE, -32'sd1, 16'd0, 1'b0);
    queue_op(ACT_REMOVE, 32'sd42, 16'd0, 1'b0);
    queue_op(ACT_INSERT, 32'sh5555_5555, 16'h5555, 1'b0);
    queue_op(ACT_INSERT, 32'shAAAA_AAAA, 16'hAAAA, 1'b0);
    queue_op(ACT_INSERT, -32'sd2, 16'd0, 1'b0);
    queue_op(ACT_REMOVE, 32'sh7FFF_FFFF, 16'd0, 1'b0);
    queue_op(ACT_CLEAR, 32'sh5555_5555, 16'd0, 1'b0);
    queue_op(ACT_QUERY, 32'sh5555_5555, 16'd0, 1'b0);
    queue_op(ACT_REMOVE, 32'sh5555_5555, 16'd0, 1'b0);
    queue_op(ACT_INSERT, 32'sd3, 16'd2, 1'b1);

    // randomized phases: fill, drain and mixed traffic over key pools
    made = 0;
    while (made < RandomItems) begin
      mode = $urandom_range(0, 3);
      if (mode == 1 && pool.size() == 0) mode = 2;
      if (mode != 1) begin
        pool.delete();
        len = (mode == 0) ? 70 : (mode == 3) ? 4 : $urandom_range(8, 40);
        repeat (len) pool.push_back(rand_key());
      end
      len = (mode == 0) ? $urandom_range(150, 220) : $urandom_range(20, 80);
      if ($urandom_range(0, 4) == 0) begin
        queue_op(ACT_CLEAR, rand_key(), rand_occ(), made == 0 || $urandom_range(0, 3) == 0);
        made++;
      end
      for (int unsigned j = 0; j < len && made < RandomItems; j++) begin
        calm_mode = (made >= CalmFrom);
        r = $urandom_range(0, 99);
        case (mode)
          0:       act = (r < 85) ? ACT_INSERT : (r < 90) ? ACT_REMOVE : ACT_QUERY;
          1:       act = (r < 70) ? ACT_REMOVE : (r < 85) ? ACT_INSERT :
                         (r < 99) ? ACT_QUERY : ACT_CLEAR;
          default: act = (r < 45) ? ACT_INSERT : (r < 80) ? ACT_REMOVE :
                         (r < 97) ? ACT_QUERY : ACT_CLEAR;
        endcase
        k = ($urandom_range(0, 9) == 0) ? rand_key() :
            pool[$urandom_range(0, pool.size() - 1)];
        queue_op(act, k, (mode == 0) ? 16'd1 : rand_occ(), made == 0);
        made++;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    while (pending_ops.size() != 0 || due_summaries.size() != 0 || req_if.valid)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS sorted_counted_multiset");
    end else begin
      $display("FAIL sorted_counted_multiset");
    end
    $finish;
  end

  // request driver: one transaction per handshake, random gaps between them
  always @(negedge clk_i) begin : drive_requests
    op_item_t nxt;
    bit       go;
    go  = 1'b0;
    nxt = '0;
    if (rst_n && (!req_if.valid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && due_summaries.size() != 0)) begin
        nxt = pending_ops.pop_front();
        go  = 1'b1;
        if (nxt.calm) tail_calm = 1'b1;
        else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
          gap_left = $urandom_range(1, 10);
      end
      req_if.valid <= go;
      if (go) begin
        req_if.action      <= nxt.act;
        req_if.key         <= nxt.key;
        req_if.occurrences <= nxt.occ;
      end
    end
  end

  // result ready: stall in bursts while traffic is not calm
  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (!tail_calm) begin
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        stall_left = $urandom_range(0, 9);
        rdy = 1'b0;
      end
    end
    rsp_if.ready <= rdy;
  end

  // monitor: compare results first, then predict the transaction just accepted
  always @(posedge clk_i) begin : watch_channels
    summary_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_summaries.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual status %0h total %0h",
                   $time, rsp_if.status, rsp_if.total_count);
        end else begin
          want = due_summaries.pop_front();
          check_field("present", 32'(want.present), 32'(rsp_if.present));
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("total_count", want.total, rsp_if.total_count);
          check_field("distinct_count", 32'(want.distinct), 32'(rsp_if.distinct_count));
          check_field("smallest_key", want.least, rsp_if.smallest_key);
          check_field("is_empty", 32'(want.vacant), 32'(rsp_if.is_empty));
        end
      end
      if (req_if.valid && req_if.ready)
        due_summaries.push_back(multiset_apply(req_if.action, req_if.key,
                                               req_if.occurrences));
      in_fire <= req_if.valid && req_if.ready;
    end
  end

  // cycle count, idling density and timeout
  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_odds <= 0;
        1:       idle_odds <= 3;
        default: idle_odds <= 8;
      endcase
    end
    if (cycles >= CycleLimit) begin
      $display("FAIL sorted_counted_multiset");
      $finish;
    end
  end

endmodule
